/* src/nmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAT mapping table package
// Request, response and cell payload types, operation and status codes.
// ----------------------------------------------------------------------------
package nmt_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TOO_MANY  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] orig_addr_hi;
      logic [63:0] orig_addr_lo;
      logic [15:0] orig_l4_port;
      logic [63:0] xlated_addr_hi;
      logic [63:0] xlated_addr_lo;
      logic [15:0] xlated_l4_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        match_valid;
      logic [63:0] match_addr_hi;
      logic [63:0] match_addr_lo;
      logic [15:0] match_port;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] orig_hi;
      logic [63:0] orig_lo;
      logic [15:0] orig_l4_port;
      logic [63:0] xlated_hi;
      logic [63:0] xlated_lo;
      logic [15:0] xlated_l4_port;
   } entry_type;

   typedef struct packed {
      logic rotate;
      logic shift;
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

/* src/nat_mapping_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAT mapping table core
// Ring of mapping cells, inspected at the top cell while the ring rotates.
// ----------------------------------------------------------------------------
// Channel   Ports                        Direction  Handshake
// request   start, busy, req_data        in         start high, busy low
// response  rsp_strobe, rsp_data         out        one cycle per strobe
//
// Add and clear are answered directly from idle. Delete rotates the ring once
// to find the newest match, then shifts the slots above it down over it.
// Lookup rotates once to count matches and, with 1 to MAX_RESULTS matches,
// once more to emit them as each match reaches the top cell.
// Synchronous reset empties the table at once; responses cannot be stalled.
// ----------------------------------------------------------------------------
module nat_mapping_table_core #(
   parameter int CAPACITY    = 64,
   parameter int MAX_RESULTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nmt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output nmt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MR_W  = $clog2(MAX_RESULTS + 2);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_EMIT   = 4'b0100,
      S_SHIFT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   nmt_pkg::req_type     key_ff, key_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]     hit_at_ff, hit_at_in;
   logic                 found_ff, found_in;
   logic [MR_W-1:0]      matches_ff, matches_in;
   logic [MR_W-1:0]      emitted_ff, emitted_in;
   logic                 strobe_ff, strobe_in;
   nmt_pkg::rsp_type     rsp_ff, rsp_in;

   nmt_pkg::cell_ctl_type ctl;
   nmt_pkg::entry_type    new_entry;
   nmt_pkg::entry_type    cell_e [CAPACITY];
   logic                  cell_v [CAPACITY];

   logic accept, wrap, hit_orig, hit_xl;
   nmt_pkg::entry_type top_e;
   logic               top_v;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign top_e  = cell_e[CAPACITY-1];
   assign top_v  = cell_v[CAPACITY-1];
   assign wrap   = (step_ff == IDX_W'(CAPACITY - 1));

   assign hit_orig = top_v && (top_e.orig_hi == key_ff.orig_addr_hi) &&
                     (top_e.orig_lo == key_ff.orig_addr_lo) &&
                     (top_e.orig_l4_port == key_ff.orig_l4_port);
   assign hit_xl   = top_v && (top_e.xlated_hi == key_ff.xlated_addr_hi) &&
                     (top_e.xlated_lo == key_ff.xlated_addr_lo) &&
                     (top_e.xlated_l4_port == key_ff.xlated_l4_port);

   assign new_entry = '{orig_hi:        req_data.orig_addr_hi,
                        orig_lo:        req_data.orig_addr_lo,
                        orig_l4_port:   req_data.orig_l4_port,
                        xlated_hi:      req_data.xlated_addr_hi,
                        xlated_lo:      req_data.xlated_addr_lo,
                        xlated_l4_port: req_data.xlated_l4_port};

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         nmt_pkg::entry_type above_e;
         logic               above_v;
         if (gi == CAPACITY - 1) begin : g_top
            assign above_e = '0;
            assign above_v = 1'b0;
         end else begin : g_mid
            assign above_e = cell_e[gi+1];
            assign above_v = cell_v[gi+1];
         end
         nmt_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .shift_from  (hit_at_ff),
            .load_at     (count_ff),
            .load_entry  (new_entry),
            .below_entry (cell_e[(gi + CAPACITY - 1) % CAPACITY]),
            .below_valid (cell_v[(gi + CAPACITY - 1) % CAPACITY]),
            .above_entry (above_e),
            .above_valid (above_v),
            .entry       (cell_e[gi]),
            .valid       (cell_v[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      hit_at_in  = hit_at_ff;
      found_in   = found_ff;
      matches_in = matches_ff;
      emitted_in = emitted_ff;
      strobe_in  = 1'b0;
      rsp_in     = '0;
      ctl        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in     = req_data;
               step_in    = '0;
               found_in   = 1'b0;
               matches_in = '0;
               emitted_in = '0;
               rsp_in.last = 1'b1;
               unique case (nmt_pkg::op_type'(req_data.op))
                  nmt_pkg::OP_ADD: begin
                     strobe_in = 1'b1;
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_in.status = nmt_pkg::ST_FULL;
                     end else begin
                        ctl.load      = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_in.status = nmt_pkg::ST_OK;
                     end
                  end
                  nmt_pkg::OP_CLEAR: begin
                     strobe_in     = 1'b1;
                     ctl.clear     = 1'b1;
                     count_in      = '0;
                     rsp_in.status = nmt_pkg::ST_OK;
                  end
                  nmt_pkg::OP_DELETE, nmt_pkg::OP_LOOKUP: begin
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            // The slot at the top cell on step t was originally slot
            // CAPACITY-1-t, so the first hit seen is the newest one.
            ctl.rotate = 1'b1;
            step_in    = step_ff + IDX_W'(1);
            if (key_ff.op == nmt_pkg::OP_DELETE) begin
               if (hit_orig && !found_ff) begin
                  found_in  = 1'b1;
                  hit_at_in = IDX_W'(CAPACITY - 1) - step_ff;
               end
               if (wrap) begin
                  if (found_in) begin
                     state_in = S_SHIFT;
                  end else begin
                     state_in      = S_IDLE;
                     strobe_in     = 1'b1;
                     rsp_in.status = nmt_pkg::ST_NOT_FOUND;
                     rsp_in.last   = 1'b1;
                  end
               end
            end else begin
               if (hit_xl && (matches_ff <= MR_W'(MAX_RESULTS))) begin
                  matches_in = matches_ff + MR_W'(1);
               end
               if (wrap) begin
                  step_in = '0;
                  if (matches_in == '0) begin
                     state_in      = S_IDLE;
                     strobe_in     = 1'b1;
                     rsp_in.status = nmt_pkg::ST_NOT_FOUND;
                     rsp_in.last   = 1'b1;
                  end else if (matches_in > MR_W'(MAX_RESULTS)) begin
                     state_in      = S_IDLE;
                     strobe_in     = 1'b1;
                     rsp_in.status = nmt_pkg::ST_TOO_MANY;
                     rsp_in.last   = 1'b1;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end

         S_EMIT: begin
            // Keep rotating to a full turn so every slot returns home.
            ctl.rotate = 1'b1;
            step_in    = step_ff + IDX_W'(1);
            if (hit_xl) begin
               strobe_in            = 1'b1;
               emitted_in           = emitted_ff + MR_W'(1);
               rsp_in.status        = nmt_pkg::ST_OK;
               rsp_in.match_valid   = 1'b1;
               rsp_in.match_addr_hi = top_e.orig_hi;
               rsp_in.match_addr_lo = top_e.orig_lo;
               rsp_in.match_port    = top_e.orig_l4_port;
               rsp_in.last          = (emitted_in == matches_ff);
            end
            if (wrap) begin
               state_in = S_IDLE;
            end
         end

         S_SHIFT: begin
            ctl.shift     = 1'b1;
            count_in      = count_ff - CNT_W'(1);
            state_in      = S_IDLE;
            strobe_in     = 1'b1;
            rsp_in.status = nmt_pkg::ST_OK;
            rsp_in.last   = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      step_ff    <= step_in;
      hit_at_ff  <= hit_at_in;
      found_ff   <= found_in;
      matches_ff <= matches_in;
      emitted_ff <= emitted_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_add_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == nmt_pkg::OP_ADD)) |=> (rsp_strobe && rsp_data.last))
      else $error("add request did not answer in the next cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_partial_in_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> (state_ff == S_EMIT))
      else $error("non-final response outside lookup emission");

   a_too_many_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != nmt_pkg::ST_OK)) |-> !rsp_data.match_valid)
      else $error("failure response carries a match");

endmodule

/* src/nmt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAT mapping table cell
// Holds one mapping slot; takes its neighbour's slot on rotate or shift down.
// ----------------------------------------------------------------------------
module nmt_cell #(
   parameter int IDX_W = 6,
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nmt_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]     shift_from,
   input  logic [CNT_W-1:0]     load_at,
   input  nmt_pkg::entry_type   load_entry,
   input  nmt_pkg::entry_type   below_entry,
   input  logic                 below_valid,
   input  nmt_pkg::entry_type   above_entry,
   input  logic                 above_valid,
   output nmt_pkg::entry_type   entry,
   output logic                 valid
);

   nmt_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.rotate) begin
         entry_in = below_entry;
         valid_in = below_valid;
      end else if (ctl.shift && (IDX_W'(INDEX) >= shift_from)) begin
         entry_in = above_entry;
         valid_in = above_valid;
      end else if (ctl.load && (CNT_W'(INDEX) == load_at)) begin
         entry_in = load_entry;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
